### rtl/cfbi_pkg.sv
// package for the csv field boundary indexer
// holds sizes, character codes, register indexes and the job record
// no dependencies
package cfbi_pkg;

    localparam int MAX_COLUMNS   = 32;
    localparam int MAX_ROWS      = 65536;
    localparam int POSITION_BITS = 32;

    localparam int RESULT_CAP = 32;
    localparam int COL_CAP    = (MAX_COLUMNS < RESULT_CAP) ? MAX_COLUMNS : RESULT_CAP;

    localparam int BYTE_W     = 8;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 17;
    localparam int BASE_W     = 22;
    localparam int CELL_W     = 21;
    localparam int POS_OUT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [COL_W-1:0]  COL_CAP_V = COL_W'(COL_CAP);
    localparam logic [ROW_W-1:0]  ROW_SAT   = '1;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'd10;

    localparam logic [BYTE_W-1:0] SEP_RESET  = 8'd44;
    localparam logic [COL_W-1:0]  COLS_RESET = 6'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

    // work handed to the sequencer for one byte: a head run and an optional fill run
    typedef struct packed {
        logic [COL_W-1:0]     start_a;
        logic [COL_W-1:0]     end_a;
        logic                 ovf_a;
        logic [POS_OUT_W-1:0] pos_a;
        logic                 fill_b;
        logic [COL_W-1:0]     start_b;
        logic [COL_W-1:0]     cols;
        logic [POS_OUT_W-1:0] pos_b;
        logic [BASE_W-1:0]    base;
    } t_job;

    // reported position is the low bits of the byte counter
    function automatic logic [POS_OUT_W-1:0] pos_out(input logic [POSITION_BITS-1:0] p);
        logic [63:0] t;
        t = 64'(p);
        return t[POS_OUT_W-1:0];
    endfunction

endpackage

### rtl/cfbi_in_if.sv
// byte input channel of the csv field boundary indexer
// depends on cfbi_pkg
interface cfbi_in_if import cfbi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/cfbi_out_if.sv
// result channel of the csv field boundary indexer
// depends on cfbi_pkg
interface cfbi_out_if import cfbi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_index;
    logic [POS_OUT_W-1:0] boundary_position;
    logic                 overflow;
    logic                 last_of_run;

    modport source (output valid, output cell_index, output boundary_position,
                    output overflow, output last_of_run, input ready);
    modport sink   (input valid, input cell_index, input boundary_position,
                    input overflow, input last_of_run, output ready);
endinterface

### rtl/cfbi_seq.sv
// result sequencer: walks the cells of a job with one shared index adder
// and feeds the output register; depends on cfbi_pkg and cfbi_out_if
module cfbi_seq import cfbi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_job        i_job,
    output logic        o_idle,
    cfbi_out_if.source  o_cell_ch
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN_A = 2'd1;
    localparam logic [1:0] S_RUN_B = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [COL_W-1:0] r_j, n_j;
    t_job             r_job;

    logic                 r_out_valid, n_out_valid;
    logic [CELL_W-1:0]    r_cell;
    logic [POS_OUT_W-1:0] r_pos;
    logic                 r_ovf;
    logic                 r_last;

    logic              room;
    logic              emit;
    logic              e_last;
    logic [COL_W-1:0]  j_inc;
    logic [BASE_W-1:0] sum;

    // shared index adder
    assign sum   = r_job.base + BASE_W'(r_j);
    assign j_inc = r_j + COL_W'(1);
    assign room  = !r_out_valid || o_cell_ch.ready;

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        emit    = 1'b0;
        e_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN_A;
                    n_j     = i_job.start_a;
                end
            end
            S_RUN_A: begin
                if (r_j >= r_job.end_a) begin
                    n_state = r_job.fill_b ? S_RUN_B : S_IDLE;
                    n_j     = r_job.start_b;
                end else if (room) begin
                    emit   = 1'b1;
                    e_last = (j_inc == r_job.end_a) && !r_job.fill_b;
                    if (j_inc == r_job.end_a) begin
                        n_state = r_job.fill_b ? S_RUN_B : S_IDLE;
                        n_j     = r_job.start_b;
                    end else begin
                        n_j = j_inc;
                    end
                end
            end
            S_RUN_B: begin
                if (r_j >= r_job.cols) begin
                    n_state = S_IDLE;
                end else if (room) begin
                    emit   = 1'b1;
                    e_last = (j_inc == r_job.cols);
                    n_j    = j_inc;
                    if (j_inc == r_job.cols) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_cell_ch.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_job <= i_job;
        end
        if (emit) begin
            if (r_state == S_RUN_A) begin
                r_cell <= r_job.ovf_a ? '0 : sum[CELL_W-1:0];
                r_pos  <= r_job.pos_a;
                r_ovf  <= r_job.ovf_a;
            end else begin
                r_cell <= sum[CELL_W-1:0];
                r_pos  <= r_job.pos_b;
                r_ovf  <= 1'b0;
            end
            r_last <= e_last;
        end
    end

    assign o_idle                      = (r_state == S_IDLE);
    assign o_cell_ch.valid             = r_out_valid;
    assign o_cell_ch.cell_index        = r_cell;
    assign o_cell_ch.boundary_position = r_pos;
    assign o_cell_ch.overflow          = r_ovf;
    assign o_cell_ch.last_of_run       = r_last;

endmodule

### rtl/csv_field_boundary_indexer.sv
// Field boundary indexer for delimited text, one byte per transfer. A byte is
// taken only while the sequencer is idle; the sequencer then emits one result
// per cycle through its single cell-index adder while the output is not stalled,
// and an end-of-file row fill may follow the results of the last byte of a file.
// A new byte may be taken while the last result still waits in the output
// register. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data.
// depends on cfbi_pkg, cfbi_in_if, cfbi_out_if and cfbi_seq
module csv_field_boundary_indexer import cfbi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cfbi_in_if.sink               i_byte_ch,
    cfbi_out_if.source            o_cell_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [BYTE_W-1:0] r_sep;
    logic [COL_W-1:0]  r_col_count;
    logic [ROW_W-1:0]  r_row_count;

    logic [POSITION_BITS-1:0] r_cnt;
    logic [ROW_W-1:0]         r_row;
    logic [BASE_W-1:0]        r_base;
    logic [COL_W-1:0]         r_col;
    logic                     r_prev_cr;

    logic [POSITION_BITS-1:0] n_cnt;
    logic [ROW_W-1:0]         n_row;
    logic [BASE_W-1:0]        n_base;
    logic [COL_W-1:0]         n_col;

    logic             seq_idle;
    logic             accept;
    logic [COL_W-1:0] cols;
    logic             in_range;
    logic             is_sep;
    logic             is_le;
    logic             col_ok;
    logic             fill;
    t_job             job;

    assign i_byte_ch.ready = seq_idle;
    assign accept          = i_byte_ch.valid && seq_idle;

    always_comb begin
        if (r_col_count == '0) begin
            cols = COL_W'(1);
        end else if (r_col_count > COL_CAP_V) begin
            cols = COL_CAP_V;
        end else begin
            cols = r_col_count;
        end
    end

    assign in_range = (r_row < r_row_count) && (32'(r_row) < 32'(MAX_ROWS));
    assign is_sep   = (i_byte_ch.data_byte == r_sep);
    assign is_le    = !is_sep && ((i_byte_ch.data_byte == CHAR_CR) ||
                      ((i_byte_ch.data_byte == CHAR_LF) && !r_prev_cr));
    assign col_ok   = (r_col < cols);
    assign n_cnt    = r_cnt + POSITION_BITS'(1);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        if (is_sep) begin
            if (col_ok) begin
                n_col = r_col + COL_W'(1);
            end
        end else if (is_le) begin
            n_col = '0;
            if (r_row < ROW_SAT) begin
                n_row = r_row + ROW_W'(1);
            end
            if (in_range) begin
                n_base = r_base + BASE_W'(cols);
            end
        end
    end

    // unterminated final row gets padded with the total length
    assign fill = i_byte_ch.last_byte && !is_le && (r_row_count != '0) &&
                  (r_row == r_row_count - ROW_W'(1)) && (32'(r_row) < 32'(MAX_ROWS)) &&
                  (n_col < cols);

    always_comb begin
        job.start_a = '0;
        job.end_a   = '0;
        job.ovf_a   = 1'b0;
        if (is_sep) begin
            job.ovf_a   = !in_range || !col_ok;
            job.start_a = job.ovf_a ? '0 : r_col;
            job.end_a   = job.ovf_a ? COL_W'(1) : r_col + COL_W'(1);
        end else if (is_le) begin
            job.ovf_a   = !in_range;
            job.start_a = job.ovf_a ? '0 : r_col;
            job.end_a   = job.ovf_a ? COL_W'(1) : cols;
        end
        job.pos_a   = pos_out(r_cnt);
        job.fill_b  = fill;
        job.start_b = n_col;
        job.cols    = cols;
        job.pos_b   = pos_out(n_cnt);
        job.base    = r_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep       <= SEP_RESET;
            r_col_count <= COLS_RESET;
            r_row_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SEPARATOR) begin
                r_sep <= i_cfg_data[BYTE_W-1:0];
            end
            if (i_cfg_idx == CFG_COLUMNS) begin
                r_col_count <= i_cfg_data[COL_W-1:0];
            end
            if (i_cfg_idx == CFG_ROWS) begin
                r_row_count <= i_cfg_data[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_row     <= '0;
            r_base    <= '0;
            r_col     <= '0;
            r_prev_cr <= 1'b0;
        end else if (accept) begin
            if (i_byte_ch.last_byte) begin
                // end of file: back to the start for the next file
                r_cnt     <= '0;
                r_row     <= '0;
                r_base    <= '0;
                r_col     <= '0;
                r_prev_cr <= 1'b0;
            end else begin
                r_cnt     <= n_cnt;
                r_row     <= n_row;
                r_base    <= n_base;
                r_col     <= n_col;
                r_prev_cr <= (i_byte_ch.data_byte == CHAR_CR);
            end
        end
    end

    cfbi_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_job     (job),
        .o_idle    (seq_idle),
        .o_cell_ch (o_cell_ch)
    );

endmodule

### rtl/cfbi_checker.sv
// port-level checks for the csv field boundary indexer, bound to the top level
// depends on cfbi_pkg
module cfbi_checker import cfbi_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [CELL_W-1:0]    i_cell_index,
    input logic [POS_OUT_W-1:0] i_boundary_position,
    input logic                 i_overflow,
    input logic                 i_last_of_run
);

    // a transfer in starts the sequencer, which is then busy and drops input ready
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_ovf_cell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_overflow) |-> (i_cell_index == '0))
        else $error("overflow result with nonzero cell index");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result offered right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn before transfer");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        ($stable(i_cell_index) && $stable(i_boundary_position) &&
         $stable(i_overflow) && $stable(i_last_of_run)))
        else $error("stalled result changed");

endmodule

bind csv_field_boundary_indexer cfbi_checker u_cfbi_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_byte_ch.valid),
    .i_in_ready          (i_byte_ch.ready),
    .i_out_valid         (o_cell_ch.valid),
    .i_out_ready         (o_cell_ch.ready),
    .i_cell_index        (o_cell_ch.cell_index),
    .i_boundary_position (o_cell_ch.boundary_position),
    .i_overflow          (o_cell_ch.overflow),
    .i_last_of_run       (o_cell_ch.last_of_run)
);
